/* hdl/planar_yuv_to_packed_rgb_unit_macros.svh */
// assertion macros for the planar yuv to packed rgb unit
// used by the port checker, no other dependencies
`ifndef PLANAR_YUV_TO_PACKED_RGB_UNIT_MACROS_SVH
`define PLANAR_YUV_TO_PACKED_RGB_UNIT_MACROS_SVH
// next-cycle implication, off while in reset
`define YUVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuvr check failed");
// next-cycle implication, checked in reset too
`define YUVR_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("yuvr check failed");
`endif

/* hdl/yuvr_pkg.sv */
// shared types and constants of the planar yuv to packed rgb unit
// no dependencies
package yuvr_pkg;

  localparam int MAX_PIXELS_DEF = 1048576;
  localparam int MAX_DIM_DEF    = 2048;

  localparam int SAMPLE_W   = 8;
  localparam int COMP_W     = 8;
  localparam int PIX_IDX_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int FMT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS    = 2'd2;

  localparam logic [FMT_W-1:0] FMT_444     = 2'd0;
  localparam logic [FMT_W-1:0] FMT_422     = 2'd1;
  localparam logic [FMT_W-1:0] FMT_420     = 2'd2;
  localparam logic [FMT_W-1:0] FMT_420_ALT = 2'd3;

  localparam logic [FMT_W-1:0]      RST_CHROMA_FORMAT = FMT_444;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_ROWS    = 12'd720;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_COLS    = 12'd1280;

  typedef enum logic [3:0] {
    GEO_LOAD_R,
    GEO_DIV_R,
    GEO_ROWS,
    GEO_PROD,
    GEO_LEN,
    GEO_LOAD_K,
    GEO_DIV_K,
    GEO_BASE,
    GEO_READY
  } geo_state_t;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [SAMPLE_W-1:0]  vbyte;
    logic                 last;
  } pix_tag_t;

endpackage

/* hdl/yuvr_if.sv */
// channel interfaces: sample input, pixel output, register write
// depends on yuvr_pkg
interface yuvr_in_if import yuvr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_start;
  modport source (output valid, output sample, output frame_start, input ready);
  modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface yuvr_out_if import yuvr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [COMP_W-1:0]    red;
  logic [COMP_W-1:0]    green;
  logic [COMP_W-1:0]    blue;
  logic                 last;
  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last, input ready);
  modport sink (input valid, input pixel_index, input red, input green,
                input blue, input last, output ready);
endinterface

interface yuvr_cfg_if import yuvr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/yuvr_geom.sv */
// configuration registers and frame geometry sequencer with a shared
// restoring divider; depends on yuvr_pkg
module yuvr_geom import yuvr_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  input  logic [$clog2(3*MAX_PIXELS+1)-1:0]   pos,
  output logic                                geo_ready,
  output logic [FMT_W-1:0]                    fmt,
  output logic [$clog2(MAX_DIM+1)-1:0]        cols,
  output logic [$clog2(MAX_PIXELS+1)-1:0]     plane_p,
  output logic [$clog2(3*MAX_PIXELS+1)-1:0]   plane_pc,
  output logic [$clog2(3*MAX_PIXELS+1)-1:0]   frame_len,
  output logic                                sync_load,
  output logic [$clog2(MAX_PIXELS)-1:0]       sync_base,
  output logic [$clog2(MAX_DIM+1)-1:0]        sync_ci
);
  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(3 * MAX_PIXELS + 1);
  localparam int CNT_W  = $clog2(PIX_W + 1);
  localparam int PROD_W = (2 * DIM_W > PIX_W) ? 2 * DIM_W : PIX_W;
  localparam int MAXC   = (MAX_PIXELS / 4) * 2;

  logic [FMT_W-1:0]      chroma_format_r;
  logic [CFG_DATA_W-1:0] frame_rows_r;
  logic [CFG_DATA_W-1:0] frame_cols_r;

  geo_state_t state_r, state_nxt;

  logic [FMT_W-1:0] fmt_r;
  logic [DIM_W-1:0] cols_r, rows_e_r, rows_r;
  logic [PIX_W-1:0] p_r;
  logic [POS_W-1:0] pc_r, len_r;

  logic [PIX_W-1:0] div_num_r, div_quo_r;
  logic [DIM_W-1:0] div_den_r, div_rem_r;
  logic [CNT_W-1:0] div_cnt_r;

  logic [DIM_W-1:0]  cols_e, rows_e, cols_l, rows_l;
  logic [FMT_W-1:0]  fmt_e;
  logic [PIX_W-1:0]  maxr;
  logic [DIM_W:0]    rem_sh;
  logic              rem_ge;
  logic [DIM_W-1:0]  rem_step;
  logic [PROD_W-1:0] prod, bprod;
  logic [PIX_W-1:0]  chroma_sz;
  logic              pos_in_v;
  logic [PIX_W-1:0]  k_num;

  function automatic logic [DIM_W-1:0] even_dim(input logic [CFG_DATA_W-1:0] d);
    logic [DIM_W-1:0] s;
    if (32'(d) > MAX_DIM) s = DIM_W'(MAX_DIM);
    else s = DIM_W'(d);
    s[0] = 1'b0;
    if (32'(s) < 2) s = DIM_W'(2);
    return s;
  endfunction

  always_comb begin
    cols_e = even_dim(frame_cols_r);
    rows_e = even_dim(frame_rows_r);
    cols_l = (32'(cols_e) > MAXC) ? DIM_W'(MAXC) : cols_e;
    fmt_e  = (chroma_format_r == FMT_420_ALT) ? FMT_420 : chroma_format_r;
    maxr   = {div_quo_r[PIX_W-1:1], 1'b0};
    rows_l = (32'(maxr) < 32'(rows_e_r)) ? DIM_W'(maxr) : rows_e_r;
    rem_sh = {div_rem_r, div_num_r[PIX_W-1]};
    rem_ge = rem_sh >= {1'b0, div_den_r};
    rem_step = rem_ge ? DIM_W'(rem_sh - {1'b0, div_den_r}) : DIM_W'(rem_sh);
    prod   = PROD_W'(rows_r) * PROD_W'(cols_r);
    bprod  = PROD_W'(DIM_W'(div_quo_r)) * PROD_W'(cols_r);
    case (fmt_r)
      FMT_444: chroma_sz = p_r;
      FMT_422: chroma_sz = p_r >> 1;
      default: chroma_sz = p_r >> 2;
    endcase
    pos_in_v = (pos >= pc_r) && (pos < len_r) && (fmt_r == FMT_420);
    k_num    = pos_in_v ? PIX_W'(pos - pc_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_format_r <= RST_CHROMA_FORMAT;
      frame_rows_r    <= RST_FRAME_ROWS;
      frame_cols_r    <= RST_FRAME_COLS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHROMA_FORMAT: chroma_format_r <= cfg_data[FMT_W-1:0];
        CFG_FRAME_ROWS:    frame_rows_r <= cfg_data;
        CFG_FRAME_COLS:    frame_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEO_LOAD_R;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      GEO_LOAD_R: state_nxt = GEO_DIV_R;
      GEO_DIV_R:  if (div_cnt_r == CNT_W'(1)) state_nxt = GEO_ROWS;
      GEO_ROWS:   state_nxt = GEO_PROD;
      GEO_PROD:   state_nxt = GEO_LEN;
      GEO_LEN:    state_nxt = GEO_LOAD_K;
      GEO_LOAD_K: state_nxt = GEO_DIV_K;
      GEO_DIV_K:  if (div_cnt_r == CNT_W'(1)) state_nxt = GEO_BASE;
      GEO_BASE:   state_nxt = GEO_READY;
      GEO_READY:  state_nxt = GEO_READY;
      default:    state_nxt = GEO_LOAD_R;
    endcase
    if (cfg_we) state_nxt = GEO_LOAD_R;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      GEO_LOAD_R: begin
        cols_r    <= cols_l;
        rows_e_r  <= rows_e;
        fmt_r     <= fmt_e;
        div_num_r <= PIX_W'(MAX_PIXELS);
        div_den_r <= cols_l;
        div_rem_r <= '0;
        div_quo_r <= '0;
        div_cnt_r <= CNT_W'(PIX_W);
      end
      GEO_DIV_R, GEO_DIV_K: begin
        div_num_r <= div_num_r << 1;
        div_rem_r <= rem_step;
        div_quo_r <= {div_quo_r[PIX_W-2:0], rem_ge};
        div_cnt_r <= div_cnt_r - CNT_W'(1);
      end
      GEO_ROWS: rows_r <= rows_l;
      GEO_PROD: p_r <= prod[PIX_W-1:0];
      GEO_LEN: begin
        pc_r  <= POS_W'(p_r) + POS_W'(chroma_sz);
        len_r <= POS_W'(p_r) + POS_W'(chroma_sz) + POS_W'(chroma_sz);
      end
      GEO_LOAD_K: begin
        div_num_r <= k_num;
        div_den_r <= cols_r >> 1;
        div_rem_r <= '0;
        div_quo_r <= '0;
        div_cnt_r <= CNT_W'(PIX_W);
      end
      default: ;
    endcase
  end

  // chroma row and column of the current v position, for 4:2:0 resync
  assign sync_load = (state_r == GEO_BASE);
  assign sync_base = ADDR_W'(bprod << 1) + ADDR_W'({div_rem_r, 1'b0});
  assign sync_ci   = div_rem_r;

  assign geo_ready = (state_r == GEO_READY);
  assign fmt       = fmt_r;
  assign cols      = cols_r;
  assign plane_p   = p_r;
  assign plane_pc  = pc_r;
  assign frame_len = len_r;
endmodule

/* hdl/yuvr_store.sv */
// luma and blue chroma sample memories, one write and one registered
// read port each; depends on yuvr_pkg
module yuvr_store import yuvr_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          y_we,
  input  logic [$clog2(MAX_PIXELS)-1:0] y_waddr,
  input  logic [SAMPLE_W-1:0]           y_wdata,
  input  logic                          u_we,
  input  logic [$clog2(MAX_PIXELS)-1:0] u_waddr,
  input  logic [SAMPLE_W-1:0]           u_wdata,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_PIXELS)-1:0] y_raddr,
  input  logic [$clog2(MAX_PIXELS)-1:0] u_raddr,
  output logic [SAMPLE_W-1:0]           y_rdata,
  output logic [SAMPLE_W-1:0]           u_rdata
);
  logic [SAMPLE_W-1:0] luma_mem [MAX_PIXELS];
  logic [SAMPLE_W-1:0] blue_mem [MAX_PIXELS];
  logic [SAMPLE_W-1:0] y_rdata_r, u_rdata_r;

  always_ff @(posedge clk) begin
    if (y_we) luma_mem[y_waddr] <= y_wdata;
    if (rd_en) y_rdata_r <= luma_mem[y_raddr];
  end

  always_ff @(posedge clk) begin
    if (u_we) blue_mem[u_waddr] <= u_wdata;
    if (rd_en) u_rdata_r <= blue_mem[u_raddr];
  end

  assign y_rdata = y_rdata_r;
  assign u_rdata = u_rdata_r;
endmodule

/* hdl/yuvr_conv.sv */
// color conversion pipeline: products, then sum, shift and clamp into
// the output register; depends on yuvr_pkg and yuvr_if
module yuvr_conv import yuvr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pix_tag_t            in_tag,
  input  logic [SAMPLE_W-1:0] luma,
  input  logic [SAMPLE_W-1:0] chroma_u,
  output logic                adv,
  yuvr_out_if.source          out_chan
);
  localparam int PRD_W = 21;
  localparam int SUM_W = 22;
  localparam int Q_SHIFT = 10;
  localparam logic signed [PRD_W-1:0] C_Y  = 21'sd1192;
  localparam logic signed [PRD_W-1:0] C_BU = 21'sd2066;
  localparam logic signed [PRD_W-1:0] C_GU = 21'sd833;
  localparam logic signed [PRD_W-1:0] C_GV = 21'sd400;
  localparam logic signed [PRD_W-1:0] C_RV = 21'sd1634;
  localparam logic signed [PRD_W-1:0] LUMA_OFS   = 21'sd16;
  localparam logic signed [PRD_W-1:0] CHROMA_OFS = 21'sd128;

  logic                    m_valid_r;
  pix_tag_t                m_tag_r;
  logic signed [PRD_W-1:0] ly_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [PRD_W-1:0] yd, ud, vd;
  logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

  logic                    out_valid_r;
  logic [PIX_IDX_W-1:0]    out_index_r;
  logic                    out_last_r;
  logic [COMP_W-1:0]       out_red_r, out_green_r, out_blue_r;

  function automatic logic [COMP_W-1:0] clamp_q10(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1]) return '0;
    if (|s[SUM_W-2:Q_SHIFT+COMP_W]) return '1;
    return s[Q_SHIFT+COMP_W-1:Q_SHIFT];
  endfunction

  assign adv = !out_valid_r || out_chan.ready;

  always_comb begin
    yd = $signed(PRD_W'(luma)) - LUMA_OFS;
    ud = $signed(PRD_W'(chroma_u)) - CHROMA_OFS;
    vd = $signed(PRD_W'(in_tag.vbyte)) - CHROMA_OFS;
    sum_r = SUM_W'(ly_r) + SUM_W'(rv_r);
    sum_g = SUM_W'(ly_r) - SUM_W'(gu_r) - SUM_W'(gv_r);
    sum_b = SUM_W'(ly_r) + SUM_W'(bu_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r   <= in_valid;
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag_r     <= in_tag;
      ly_r        <= yd * C_Y;
      rv_r        <= vd * C_RV;
      gu_r        <= ud * C_GU;
      gv_r        <= vd * C_GV;
      bu_r        <= ud * C_BU;
      out_index_r <= m_tag_r.pixel_index;
      out_last_r  <= m_tag_r.last;
      out_red_r   <= clamp_q10(sum_r);
      out_green_r <= clamp_q10(sum_g);
      out_blue_r  <= clamp_q10(sum_b);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_index = out_index_r;
  assign out_chan.last        = out_last_r;
  assign out_chan.red         = out_red_r;
  assign out_chan.green       = out_green_r;
  assign out_chan.blue        = out_blue_r;
endmodule

/* hdl/planar_yuv_to_packed_rgb_unit.sv */
// Planar YUV to packed RGB converter, top level.
// in_chan takes one byte of a planar frame per request in file order: the
// Y plane, then U, then V; frame_start puts the byte back at the first Y.
// Y and U bytes go to two sample memories and produce nothing. Each V byte
// yields the pixels of its chroma site on out_chan: one (4:4:4), two
// (4:2:2) or a 2x2 block (4:2:0), the final one flagged by last.
// cfg_chan writes chroma_format, frame_rows and frame_cols; cfg_ready is
// always high.
// A Y or U byte is taken without holding in_ready low; a V byte yields one
// pixel per cycle while out_chan does not stall, set by the single read port
// of the luma memory. Its pixels pass the issue, memory read, product and
// output registers. A stalled receiver holds the output register and the
// pipeline behind it; Y and U bytes are still taken while no V byte is
// waiting to issue. Reset and every register write start a geometry
// sequence (two serial divisions) with in_ready low.
// The sample memories are not cleared.
// depends on yuvr_pkg, yuvr_if, yuvr_geom, yuvr_store, yuvr_conv
module planar_yuv_to_packed_rgb_unit import yuvr_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  yuvr_in_if.sink    in_chan,
  yuvr_out_if.source out_chan,
  yuvr_cfg_if.sink   cfg_chan
);
  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(3 * MAX_PIXELS + 1);

  logic             geo_ready;
  logic [FMT_W-1:0] fmt;
  logic [DIM_W-1:0] cols;
  logic [PIX_W-1:0] plane_p;
  logic [POS_W-1:0] plane_pc, frame_len;
  logic             sync_load;
  logic [ADDR_W-1:0] sync_base;
  logic [DIM_W-1:0] sync_ci;
  logic             adv;

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_start, pos_cur, pos_inc;
  logic              in_fire, is_y, is_u, is_v, v_first;
  logic [ADDR_W-1:0] k_u, k_v, base_cur, base_sel, vbase_r, vbase_nxt;
  logic [DIM_W-1:0]  ci_cur, vci_r, vci_nxt;
  logic [1:0]        lastcnt_sel;

  logic                iss_valid_r;
  logic [ADDR_W-1:0]   iss_base_r, iss_k_r, iss_addr;
  logic [SAMPLE_W-1:0] iss_vbyte_r;
  logic [1:0]          iss_cnt_r, iss_lastcnt_r;
  logic                iss_last, issue_fire;
  pix_tag_t            tag_nxt, rd_tag_r;
  logic                rd_valid_r;
  logic [SAMPLE_W-1:0] y_rdata, u_rdata;

  yuvr_geom #(.MAX_PIXELS(MAX_PIXELS), .MAX_DIM(MAX_DIM)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_chan.valid),
    .cfg_index (cfg_chan.reg_index),
    .cfg_data  (cfg_chan.wdata),
    .pos       (pos_r),
    .geo_ready (geo_ready),
    .fmt       (fmt),
    .cols      (cols),
    .plane_p   (plane_p),
    .plane_pc  (plane_pc),
    .frame_len (frame_len),
    .sync_load (sync_load),
    .sync_base (sync_base),
    .sync_ci   (sync_ci)
  );

  assign cfg_chan.ready = 1'b1;

  assign iss_last   = (iss_cnt_r == iss_lastcnt_r);
  assign issue_fire = iss_valid_r && adv;
  // the next request may arrive while the last pixel read issues
  assign in_chan.ready = geo_ready && (!iss_valid_r || (iss_last && adv));
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    pos_start = in_chan.frame_start ? '0 : pos_r;
    pos_cur   = (pos_start >= frame_len) ? '0 : pos_start;
    is_y      = pos_cur < POS_W'(plane_p);
    is_u      = !is_y && (pos_cur < plane_pc);
    is_v      = !is_y && !is_u;
    k_u       = ADDR_W'(pos_cur - POS_W'(plane_p));
    k_v       = ADDR_W'(pos_cur - plane_pc);
    v_first   = (pos_cur == plane_pc);
    ci_cur    = v_first ? '0 : vci_r;
    base_cur  = v_first ? '0 : vbase_r;
    pos_inc   = pos_cur + POS_W'(1);
    pos_nxt   = (pos_inc >= frame_len) ? '0 : pos_inc;
    if (ci_cur + DIM_W'(1) == (cols >> 1)) begin
      vci_nxt   = '0;
      vbase_nxt = base_cur + ADDR_W'(2) + ADDR_W'(cols);
    end else begin
      vci_nxt   = ci_cur + DIM_W'(1);
      vbase_nxt = base_cur + ADDR_W'(2);
    end
    case (fmt)
      FMT_444: begin
        base_sel    = k_v;
        lastcnt_sel = 2'd0;
      end
      FMT_422: begin
        base_sel    = k_v << 1;
        lastcnt_sel = 2'd1;
      end
      default: begin
        base_sel    = base_cur;
        lastcnt_sel = 2'd3;
      end
    endcase
    iss_addr = iss_base_r + (iss_cnt_r[1] ? ADDR_W'(cols) : '0) + ADDR_W'(iss_cnt_r[0]);
    tag_nxt.pixel_index = PIX_IDX_W'(iss_addr);
    tag_nxt.vbyte       = iss_vbyte_r;
    tag_nxt.last        = iss_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      iss_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (in_fire) pos_r <= pos_nxt;
      if (in_fire && is_v) iss_valid_r <= 1'b1;
      else if (issue_fire && iss_last) iss_valid_r <= 1'b0;
      if (adv) rd_valid_r <= issue_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_v) begin
      iss_base_r    <= base_sel;
      iss_k_r       <= k_v;
      iss_vbyte_r   <= in_chan.sample;
      iss_cnt_r     <= 2'd0;
      iss_lastcnt_r <= lastcnt_sel;
    end else if (issue_fire) begin
      iss_cnt_r <= iss_cnt_r + 2'd1;
    end
    if (adv) rd_tag_r <= tag_nxt;
    if (sync_load) begin
      vci_r   <= sync_ci;
      vbase_r <= sync_base;
    end else if (in_fire && is_v && fmt == FMT_420) begin
      vci_r   <= vci_nxt;
      vbase_r <= vbase_nxt;
    end
  end

  yuvr_store #(.MAX_PIXELS(MAX_PIXELS)) u_store (
    .clk     (clk),
    .y_we    (in_fire && is_y),
    .y_waddr (pos_cur[ADDR_W-1:0]),
    .y_wdata (in_chan.sample),
    .u_we    (in_fire && is_u),
    .u_waddr (k_u),
    .u_wdata (in_chan.sample),
    .rd_en   (adv),
    .y_raddr (iss_addr),
    .u_raddr (iss_k_r),
    .y_rdata (y_rdata),
    .u_rdata (u_rdata)
  );

  yuvr_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_valid_r),
    .in_tag   (rd_tag_r),
    .luma     (y_rdata),
    .chroma_u (u_rdata),
    .adv      (adv),
    .out_chan (out_chan)
  );
endmodule

/* hdl/yuvr_checker.sv */
// port checker for the planar yuv to packed rgb unit and its bind
// depends on planar_yuv_to_packed_rgb_unit_macros.svh and yuvr_pkg
`include "planar_yuv_to_packed_rgb_unit_macros.svh"

module yuvr_checker import yuvr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_IDX_W-1:0] out_pixel_index,
  input logic [COMP_W-1:0]    out_red,
  input logic [COMP_W-1:0]    out_green,
  input logic [COMP_W-1:0]    out_blue,
  input logic                 out_last,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);
  `YUVR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `YUVR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_pixel_index) && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last))
  `YUVR_ASSERT_NEXT(a_cfg_blocks_in, clk, rst_n, cfg_valid && cfg_ready, !in_ready)
  `YUVR_ASSERT_NEXT_ANY(a_reset_clears, clk, !rst_n, !out_valid && !in_ready)
endmodule

bind planar_yuv_to_packed_rgb_unit yuvr_checker u_yuvr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_pixel_index (out_chan.pixel_index),
  .out_red         (out_chan.red),
  .out_green       (out_chan.green),
  .out_blue        (out_chan.blue),
  .out_last        (out_chan.last),
  .cfg_valid       (cfg_chan.valid),
  .cfg_ready       (cfg_chan.ready)
);
